>>> sv/mbc_pkg.sv
// shared types, constants and helpers for the mailbox bridge
package mbc_pkg;

  localparam int HoldWidth  = 17;
  localparam int TickWidth  = 30;
  localparam int CountWidth = 24;
  localparam int AccWidth   = TickWidth + 1;

  localparam logic [31:0] HOST_MASK = 32'h0000_ff06;
  localparam logic [31:0] COP_MASK  = 32'he000_003f;

  localparam logic [31:0] HOST_DATA   = 32'h0000_3800;
  localparam logic [31:0] HOST_SIGNAL = 32'h0000_3802;
  localparam logic [31:0] HOST_CTRL   = 32'h0000_3804;

  localparam logic [31:0] COP_OUTBOX   = 32'h4000_0000;
  localparam logic [31:0] COP_INBOX    = 32'h4000_0010;
  localparam logic [31:0] COP_STATUS   = 32'h4000_0020;
  localparam logic [31:0] COP_LATCH_LO = 32'h4000_0020;
  localparam logic [31:0] COP_LATCH_MD = 32'h4000_0024;
  localparam logic [31:0] COP_LATCH_HI = 32'h4000_0028;
  localparam logic [31:0] COP_ARM      = 32'h4000_002c;

  localparam logic [TickWidth-1:0] OWED_CAP = 30'h3fff_ffff;
  localparam logic [HoldWidth-1:0] BOOT_HOLD_RESET = 17'h1_0000;

  localparam logic [2:0] REQ_HOST_RD = 3'd0;
  localparam logic [2:0] REQ_HOST_WR = 3'd1;
  localparam logic [2:0] REQ_COP_RD  = 3'd2;
  localparam logic [2:0] REQ_COP_WR  = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  typedef struct packed {
    logic                  host_to_cop_pending;
    logic [7:0]            host_to_cop_byte;
    logic                  cop_to_host_pending;
    logic [7:0]            cop_to_host_byte;
    logic                  signal_flag;
    logic                  ready_flag;
    logic                  reset_line;
    logic [HoldWidth-1:0]  boot_accumulator;
    logic [CountWidth-1:0] countdown;
    logic [CountWidth-1:0] countdown_latch;
  } mbc_state_t;

  typedef struct packed {
    logic                  ready_flag;
    logic [HoldWidth-1:0]  boot_accumulator;
    logic [CountWidth-1:0] countdown;
  } mbc_tick_upd_t;

  function automatic logic [7:0] status_of(mbc_state_t s);
    return {s.ready_flag, 3'b000, s.host_to_cop_pending, s.signal_flag, 1'b0,
            s.cop_to_host_pending};
  endfunction

endpackage

>>> sv/mbc_tick.sv
// tick unit: boot hold accumulation and floored countdown decrement
module mbc_tick
  import mbc_pkg::*;
(
  input  mbc_state_t             st,
  input  logic [HoldWidth-1:0]   boot_hold_cycles,
  input  logic [TickWidth-1:0]   tick_count,
  output mbc_tick_upd_t          upd
);

  logic [AccWidth-1:0]  acc;
  logic [AccWidth-1:0]  hold_ext;
  logic [AccWidth-1:0]  rem;
  logic [TickWidth-1:0] owed;
  logic                 hold_met;

  always_comb begin
    acc      = {{(AccWidth-HoldWidth){1'b0}}, st.boot_accumulator}
             + {1'b0, tick_count};
    hold_ext = {{(AccWidth-HoldWidth){1'b0}}, boot_hold_cycles};
    hold_met = (acc >= hold_ext);
    rem      = st.ready_flag ? acc : (acc - hold_ext);
    owed     = (rem > {1'b0, OWED_CAP}) ? OWED_CAP : rem[TickWidth-1:0];

    upd.ready_flag       = st.ready_flag;
    upd.boot_accumulator = st.boot_accumulator;
    upd.countdown        = st.countdown;

    if (!st.reset_line && (acc != '0)) begin
      if (!st.ready_flag && !hold_met) begin
        // still holding, below boot threshold
        upd.boot_accumulator = acc[HoldWidth-1:0];
      end else begin
        upd.ready_flag       = 1'b1;
        upd.boot_accumulator = '0;
        if ({{(TickWidth-CountWidth){1'b0}}, st.countdown} > owed) begin
          upd.countdown = st.countdown - owed[CountWidth-1:0];
        end else begin
          upd.countdown = '0;
        end
      end
    end
  end

endmodule

>>> sv/mailbox_bridge_with_countdown_top.sv
// top level of the host/coprocessor mailbox bridge with countdown
//
// input channel (in_valid/in_ready) carries one transaction per item: a host
// read or write, a coprocessor read or write, or a tick with a clock count.
// every input transaction yields exactly one result transaction on the
// output channel (out_valid/out_ready): the read byte (zero unless a read),
// the status byte after the item and the countdown after the item.
// a result is registered at the edge that accepts the item
// throughput: 1 item per cycle unless the output stalls; the whole state
// update is one combinational pass from the state registers (address decode,
// tick add/compare/subtract) into the state and result registers
// stall: while a result waits, in_ready follows out_ready, so a new item is
// taken in the same cycle the waiting result leaves
// reset: rst clears all mailbox state, the reset line and the output valid,
// and restores the boot hold register to 65536
// config: cfg_write_en loads boot_hold_cycles at once; write only when idle
// a host control write with bit0 set while the reset line is low clears all
// bridge state; while the line stays high, ticks are dropped
module mailbox_bridge_with_countdown_top
  import mbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write_en,
  input  logic [HoldWidth-1:0]  cfg_write_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            req_type,
  input  logic [31:0]           address,
  input  logic [7:0]            write_data,
  input  logic [TickWidth-1:0]  tick_count,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            read_data,
  output logic [7:0]            status_byte,
  output logic [CountWidth-1:0] countdown_value
);

  logic [HoldWidth-1:0] boot_hold_cycles;
  mbc_state_t           st;
  mbc_state_t           st_next;
  mbc_tick_upd_t        tick_upd;
  logic [7:0]           rd_next;
  logic [31:0]          host_addr;
  logic [31:0]          cop_addr;
  logic                 accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign host_addr = address & HOST_MASK;
  assign cop_addr  = address & COP_MASK;

  mbc_tick u_tick (
    .st               (st),
    .boot_hold_cycles (boot_hold_cycles),
    .tick_count       (tick_count),
    .upd              (tick_upd)
  );

  // next state and read byte for the transaction at the input
  always_comb begin
    st_next = st;
    rd_next = 8'h00;
    unique case (req_type)
      REQ_HOST_RD: begin
        priority if (host_addr == HOST_DATA) begin
          if (st.cop_to_host_pending) begin
            st_next.cop_to_host_pending = 1'b0;
            rd_next = st.cop_to_host_byte;
          end
        end else if (host_addr == HOST_SIGNAL) begin
          st_next.signal_flag = 1'b0;
        end else if (host_addr == HOST_CTRL) begin
          rd_next = status_of(st);
        end else begin
          // unmapped host read returns zero
        end
      end
      REQ_HOST_WR: begin
        priority if (host_addr == HOST_SIGNAL) begin
          st_next.host_to_cop_pending = 1'b1;
          st_next.host_to_cop_byte    = write_data;
        end else if (host_addr == HOST_CTRL) begin
          // rising edge of the reset line wipes the bridge
          if (!st.reset_line && write_data[0]) begin
            st_next = '0;
          end
          st_next.reset_line = write_data[0];
        end else begin
          // unmapped host write does nothing
        end
      end
      REQ_COP_RD: begin
        priority if (cop_addr == COP_INBOX) begin
          if (st.host_to_cop_pending) begin
            st_next.host_to_cop_pending = 1'b0;
            rd_next = st.host_to_cop_byte;
          end
        end else if (cop_addr == COP_STATUS) begin
          rd_next = status_of(st);
        end else begin
          // unmapped coprocessor read returns zero
        end
      end
      REQ_COP_WR: begin
        priority if (cop_addr == COP_OUTBOX) begin
          st_next.cop_to_host_pending = 1'b1;
          st_next.cop_to_host_byte    = write_data;
        end else if (cop_addr == COP_INBOX) begin
          st_next.signal_flag = 1'b1;
        end else if (cop_addr == COP_LATCH_LO) begin
          st_next.countdown_latch[7:0] = write_data;
        end else if (cop_addr == COP_LATCH_MD) begin
          st_next.countdown_latch[15:8] = write_data;
        end else if (cop_addr == COP_LATCH_HI) begin
          st_next.countdown_latch[23:16] = write_data;
        end else if (cop_addr == COP_ARM) begin
          st_next.countdown = st.countdown_latch;
        end else begin
          // unmapped coprocessor write does nothing
        end
      end
      REQ_TICK: begin
        st_next.ready_flag       = tick_upd.ready_flag;
        st_next.boot_accumulator = tick_upd.boot_accumulator;
        st_next.countdown        = tick_upd.countdown;
      end
      default: begin
        // unused request codes leave everything as is
      end
    endcase
  end

  // bridge state and boot hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= '0;
      boot_hold_cycles <= BOOT_HOLD_RESET;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (cfg_write_en) begin
        boot_hold_cycles <= cfg_write_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data       <= rd_next;
      status_byte     <= status_of(st_next);
      countdown_value <= st_next.countdown;
    end
  end

`ifndef NO_ASSERTIONS
  // a reset-line rising edge leaves an all-zero status and countdown
  a_reset_edge_clears: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_HOST_WR && host_addr == HOST_CTRL &&
    write_data[0] && !st.reset_line
    |=> out_valid && status_byte == 8'h00 && countdown_value == '0)
    else $error("reset line edge did not clear bridge state");

  // ticks are dropped while the reset line is held
  a_tick_dropped_in_reset: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_TICK && st.reset_line
    |=> st.countdown == $past(st.countdown) &&
        st.ready_flag == $past(st.ready_flag) &&
        st.boot_accumulator == $past(st.boot_accumulator))
    else $error("tick changed state while reset line held");

  // input is only held off by a waiting result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // the output register reflects the committed countdown
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> countdown_value == st.countdown && status_byte == status_of(st))
    else $error("result register out of step with bridge state");
`endif

endmodule

>>> tb/sv/mbc_checker.sv
// checker that predicts and compares every result of the mailbox bridge
module mbc_checker
  import mbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [HoldWidth-1:0]  cfg_write_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            req_type,
  input  logic [31:0]           address,
  input  logic [7:0]            write_data,
  input  logic [TickWidth-1:0]  tick_count,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            read_data,
  input  logic [7:0]            status_byte,
  input  logic [CountWidth-1:0] countdown_value,
  output int                    pending,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]            rd;
    logic [7:0]            status;
    logic [CountWidth-1:0] count;
  } bridge_result_t;

  mbc_state_t           bridge;
  logic [HoldWidth-1:0] hold_cycles;
  bridge_result_t       due_results[$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic logic [7:0] flags_byte(mbc_state_t s);
    logic [7:0] b;
    b    = '0;
    b[0] = s.cop_to_host_pending;
    b[2] = s.signal_flag;
    b[3] = s.host_to_cop_pending;
    b[7] = s.ready_flag;
    return b;
  endfunction

  // applies one transaction to the bridge copy and returns what it should yield
  function automatic bridge_result_t advance_bridge(logic [2:0] req, logic [31:0] addr,
                                                    logic [7:0] wd,
                                                    logic [TickWidth-1:0] ticks);
    logic [31:0]    h;
    logic [31:0]    c;
    logic [63:0]    acc;
    logic [63:0]    owed;
    logic           spend;
    bridge_result_t r;
    h    = addr & HOST_MASK;
    c    = addr & COP_MASK;
    r.rd = '0;
    case (req)
      REQ_HOST_RD: begin
        if (h == HOST_DATA) begin
          if (bridge.cop_to_host_pending) begin
            bridge.cop_to_host_pending = 1'b0;
            r.rd = bridge.cop_to_host_byte;
          end
        end else if (h == HOST_SIGNAL) begin
          bridge.signal_flag = 1'b0;
        end else if (h == HOST_CTRL) begin
          r.rd = flags_byte(bridge);
        end
      end
      REQ_HOST_WR: begin
        if (h == HOST_SIGNAL) begin
          bridge.host_to_cop_pending = 1'b1;
          bridge.host_to_cop_byte    = wd;
        end else if (h == HOST_CTRL) begin
          // rising reset line wipes all but the line itself
          if (!bridge.reset_line && wd[0]) bridge = '0;
          bridge.reset_line = wd[0];
        end
      end
      REQ_COP_RD: begin
        if (c == COP_INBOX) begin
          if (bridge.host_to_cop_pending) begin
            bridge.host_to_cop_pending = 1'b0;
            r.rd = bridge.host_to_cop_byte;
          end
        end else if (c == COP_STATUS) begin
          r.rd = flags_byte(bridge);
        end
      end
      REQ_COP_WR: begin
        case (c)
          COP_OUTBOX: begin
            bridge.cop_to_host_pending = 1'b1;
            bridge.cop_to_host_byte    = wd;
          end
          COP_INBOX:    bridge.signal_flag = 1'b1;
          COP_LATCH_LO: bridge.countdown_latch[7:0]   = wd;
          COP_LATCH_MD: bridge.countdown_latch[15:8]  = wd;
          COP_LATCH_HI: bridge.countdown_latch[23:16] = wd;
          COP_ARM:      bridge.countdown = bridge.countdown_latch;
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (!bridge.reset_line) begin
          acc = bridge.boot_accumulator;
          acc = acc + ticks;
          if (acc != 0) begin
            spend = 1'b1;
            if (!bridge.ready_flag) begin
              if (acc >= hold_cycles) begin
                acc = acc - hold_cycles;
                bridge.ready_flag = 1'b1;
              end else begin
                bridge.boot_accumulator = acc[HoldWidth-1:0];
                spend = 1'b0;
              end
            end
            if (spend) begin
              owed = (acc > OWED_CAP) ? OWED_CAP : acc;
              if (owed != 0 && bridge.countdown != 0) begin
                if (bridge.countdown > owed)
                  bridge.countdown = bridge.countdown - owed[CountWidth-1:0];
                else
                  bridge.countdown = '0;
              end
              bridge.boot_accumulator = '0;
            end
          end
        end
      end
      default: ;
    endcase
    r.status = flags_byte(bridge);
    r.count  = bridge.countdown;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    bridge_result_t want;
    if (rst) begin
      bridge      = '0;
      hold_cycles = BOOT_HOLD_RESET;
      due_results.delete();
    end else begin
      if (cfg_write_en) hold_cycles = cfg_write_data;
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected: read_data %h status %h count %h",
                   $time, read_data, status_byte, countdown_value);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (read_data !== want.rd) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rd, read_data);
            fail_count++;
          end
          if (status_byte !== want.status) begin
            $display("%0t: status_byte expected %h actual %h", $time, want.status,
                     status_byte);
            fail_count++;
          end
          if (countdown_value !== want.count) begin
            $display("%0t: countdown_value expected %h actual %h", $time, want.count,
                     countdown_value);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(advance_bridge(req_type, address, write_data, tick_count));
    end
    pending <= due_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench top: traffic into the mailbox bridge, long stalls and the verdict
module tb_top
  import mbc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD     = 5;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int LONG_HOLD_OFF   = 200;

  // request codes the bridge leaves unused
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  logic                  clk             = 1'b0;
  logic                  rst             = 1'b1;
  logic                  cfg_write_en    = 1'b0;
  logic [HoldWidth-1:0]  cfg_write_data  = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic [2:0]            req_type        = REQ_HOST_RD;
  logic [31:0]           address         = '0;
  logic [7:0]            write_data      = '0;
  logic [TickWidth-1:0]  tick_count      = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [7:0]            read_data;
  logic [7:0]            status_byte;
  logic [CountWidth-1:0] countdown_value;

  int pending;
  int fail_count;

  // idling knobs, changed per phase by the stimulus process
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // a bump of the request count asks the receiver for one long hold-off
  int hold_off_req = 0;
  int hold_off_ack = 0;
  int items_sent   = 0;

  always #HALF_PERIOD clk = ~clk;

  mailbox_bridge_with_countdown_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .address         (address),
    .write_data      (write_data),
    .tick_count      (tick_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .status_byte     (status_byte),
    .countdown_value (countdown_value)
  );

  mbc_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .address         (address),
    .write_data      (write_data),
    .tick_count      (tick_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .status_byte     (status_byte),
    .countdown_value (countdown_value),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  // host-side address that decodes to target, don't-care bits random
  function automatic logic [31:0] host_addr(logic [31:0] target);
    return ($urandom() & ~HOST_MASK) | target;
  endfunction

  // coprocessor-side address that decodes to target, don't-care bits random
  function automatic logic [31:0] cop_addr(logic [31:0] target);
    return ($urandom() & ~COP_MASK) | target;
  endfunction

  // random data byte
  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  // random tick count over the full field
  function automatic logic [TickWidth-1:0] rnd_ticks();
    return TickWidth'($urandom());
  endfunction

  // tick sizes: some zero, some small so the countdown moves without bottoming
  // out, some around the boot hold, and huge ones
  function automatic logic [TickWidth-1:0] pick_ticks();
    case ($urandom_range(9))
      0:       return '0;
      1:       return OWED_CAP;
      2, 3, 4: return TickWidth'($urandom_range(1000));
      5, 6, 7: return TickWidth'($urandom_range(140000));
      default: return rnd_ticks();
    endcase
  endfunction

  // one transaction on the input channel, with random idle cycles ahead of it;
  // valid stays high at return so a back-to-back item needs no second write
  task automatic send_item(logic [2:0] req, logic [31:0] addr, logic [7:0] wd,
                           logic [TickWidth-1:0] ticks);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    address    <= addr;
    write_data <= wd;
    tick_count <= ticks;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  // stop offering and wait until every predicted result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // only called while the bridge is idle
  task automatic write_hold(logic [HoldWidth-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // a short, mostly well-formed exchange with random content, or some noise
  task automatic run_scenario();
    int         n;
    logic [7:0] hi_byte;
    case ($urandom_range(9))
      0, 1, 2: begin
        // host hands a byte over, coprocessor picks it up
        send_item(REQ_HOST_WR, host_addr(HOST_SIGNAL), rnd_byte(), rnd_ticks());
        if ($urandom_range(1))
          send_item(REQ_HOST_RD, host_addr(HOST_CTRL), rnd_byte(), rnd_ticks());
        if ($urandom_range(3))
          send_item(REQ_COP_RD, cop_addr(COP_INBOX), rnd_byte(), rnd_ticks());
        if ($urandom_range(1))
          send_item(REQ_COP_RD, cop_addr(COP_STATUS), rnd_byte(), rnd_ticks());
      end
      3, 4: begin
        // coprocessor answers and signals, host polls status and reads
        send_item(REQ_COP_WR, cop_addr(COP_OUTBOX), rnd_byte(), rnd_ticks());
        if ($urandom_range(1))
          send_item(REQ_COP_WR, cop_addr(COP_INBOX), rnd_byte(), rnd_ticks());
        send_item(REQ_HOST_RD, host_addr(HOST_CTRL), rnd_byte(), rnd_ticks());
        n = $urandom_range(1, 2);
        repeat (n)
          send_item(REQ_HOST_RD, host_addr(HOST_DATA), rnd_byte(), rnd_ticks());
        if ($urandom_range(1))
          send_item(REQ_HOST_RD, host_addr(HOST_SIGNAL), rnd_byte(), rnd_ticks());
      end
      5, 6: begin
        // load the latch bytewise, arm, then let time pass; a small top byte
        // keeps the counter within reach of the ticks
        hi_byte = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        if ($urandom_range(4))
          send_item(REQ_COP_WR, cop_addr(COP_LATCH_LO), rnd_byte(), rnd_ticks());
        if ($urandom_range(4))
          send_item(REQ_COP_WR, cop_addr(COP_LATCH_MD), rnd_byte(), rnd_ticks());
        if ($urandom_range(4))
          send_item(REQ_COP_WR, cop_addr(COP_LATCH_HI), hi_byte, rnd_ticks());
        send_item(REQ_COP_WR, cop_addr(COP_ARM), rnd_byte(), rnd_ticks());
        n = $urandom_range(1, 4);
        repeat (n) send_item(REQ_TICK, $urandom(), rnd_byte(), pick_ticks());
      end
      7: begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(REQ_TICK, $urandom(), rnd_byte(), pick_ticks());
      end
      8: begin
        // anything at all, mostly unmapped
        send_item(3'($urandom_range(7)), $urandom(), rnd_byte(), rnd_ticks());
      end
      default: begin
        // host reset line: set about a quarter of the time
        send_item(REQ_HOST_WR, host_addr(HOST_CTRL),
                  {7'($urandom_range(127)), ($urandom_range(3) == 0)}, rnd_ticks());
      end
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off on request, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_ack != hold_off_req) begin
        hold_off_ack = hold_off_req;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_OFF) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // stimulus and verdict
  initial begin
    int   phase;
    int   goal;
    int   half;
    logic mid_done;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, boot hold at its reset value
    send_item(REQ_HOST_RD, HOST_CTRL, 8'h00, '0);           // status straight after reset
    send_item(REQ_TICK, '0, 8'h00, '0);                     // zero tick, empty accumulator
    send_item(REQ_TICK, '0, 8'hff, 30'd65535);              // one short of the boot hold
    send_item(REQ_COP_WR, COP_LATCH_LO, 8'hff, '0);
    send_item(REQ_COP_WR, COP_LATCH_MD, 8'hff, '0);
    send_item(REQ_COP_WR, COP_LATCH_HI, 8'hff, '0);
    send_item(REQ_COP_WR, COP_ARM, 8'h00, '0);              // counter at full scale
    send_item(REQ_TICK, '0, 8'h00, 30'd3);                  // boot ends, excess counts down
    send_item(REQ_TICK, 32'hffff_ffff, 8'h00, OWED_CAP);    // largest tick, floor at zero
    send_item(REQ_HOST_WR, ~HOST_MASK | HOST_SIGNAL, 8'ha5, '0);
    send_item(REQ_COP_RD, COP_STATUS, 8'h00, '0);
    send_item(REQ_COP_RD, ~COP_MASK | COP_INBOX, 8'hff, '0);
    send_item(REQ_COP_RD, COP_INBOX, 8'h00, '0);            // nothing pending, reads zero
    send_item(REQ_COP_WR, COP_OUTBOX, 8'h5a, '0);
    send_item(REQ_COP_WR, COP_INBOX, 8'h00, '0);            // raise the signal
    send_item(REQ_HOST_RD, HOST_CTRL, 8'h00, '0);
    send_item(REQ_HOST_RD, HOST_DATA, 8'h00, '0);
    send_item(REQ_HOST_RD, HOST_DATA, 8'h00, '0);           // already taken, reads zero
    send_item(REQ_HOST_RD, HOST_SIGNAL, 8'h00, '0);         // clear the signal
    send_item(REQ_HOST_RD, '0, 8'h00, '0);                  // unmapped host read
    send_item(REQ_COP_WR, 32'hffff_ffff, 8'hff, OWED_CAP);  // unmapped coprocessor write
    send_item(REQ_SPARE_FIRST, HOST_CTRL, 8'h01, 30'd5);    // unused request codes
    send_item(REQ_SPARE_LAST, COP_ARM, 8'hff, OWED_CAP);
    send_item(REQ_HOST_WR, HOST_CTRL, 8'h01, '0);           // reset edge clears the bridge
    send_item(REQ_TICK, '0, 8'h00, 30'd100000);             // dropped while the line is high
    send_item(REQ_COP_WR, COP_OUTBOX, 8'h3c, '0);           // still carried out
    send_item(REQ_HOST_WR, HOST_CTRL, 8'h00, '0);           // release, no clear
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      // new boot hold only while idle: extremes first
      case (phase)
        0:       write_hold(17'd1);
        1:       write_hold(BOOT_HOLD_RESET);
        2:       write_hold('0);
        3:       write_hold(17'h1_ffff);
        default: write_hold(HoldWidth'($urandom_range(70000, 1)));
      endcase
      // idling pattern: none, sender half idle, receiver half stalled, both light
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      goal     = items_sent + ITEMS_PER_PHASE;
      half     = items_sent + ITEMS_PER_PHASE / 2;
      mid_done = 1'b0;
      while (items_sent < goal) begin
        if (!mid_done && items_sent >= half) begin
          mid_done = 1'b1;
          // long receiver hold-off while the sender keeps offering
          if (phase % 4 == 0) hold_off_req++;
          // sender pauses until everything has come back
          else if (phase % 4 == 1) wait_drained();
        end
        run_scenario();
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/mbc_pkg.sv
sv/mbc_tick.sv
sv/mailbox_bridge_with_countdown_top.sv
tb/sv/mbc_checker.sv
tb/sv/tb_top.sv
